>>> design/huffman_tree_load_and_decode_macros.svh
// Assertion macros shared by the Huffman tree load and decode block.
// They sample on clk_i and are disabled while rst_ni is low.
`ifndef HUFFMAN_TREE_LOAD_AND_DECODE_MACROS_SVH
`define HUFFMAN_TREE_LOAD_AND_DECODE_MACROS_SVH

// A condition that holds at every clock edge.
`define HTLD_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// A trigger that forces a consequence at the next clock edge.
`define HTLD_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

>>> design/htld_pkg.sv
package htld_pkg;

  localparam int MaxNodes   = 512;
  localparam int StackDepth = 256;
  localparam int SymbolBits = 8;

  localparam int NodeW      = $clog2(MaxNodes);
  localparam int NodeCntW   = $clog2(MaxNodes + 1);
  localparam int StackAddrW = $clog2(StackDepth);
  localparam int StackCntW  = $clog2(StackDepth + 1);

  typedef enum logic [1:0] {
    KindFlag    = 2'd0,
    KindSymbol  = 2'd1,
    KindPayload = 2'd2,
    KindRestart = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    EvSymbol   = 2'd0,
    EvLoadDone = 2'd1,
    EvError    = 2'd2
  } event_e;

  typedef enum logic [2:0] {
    ErrNone       = 3'd0,
    ErrNoTree     = 3'd1,
    ErrOrder      = 3'd2,
    ErrOverflow   = 3'd3,
    ErrSingleLeaf = 3'd4
  } error_e;

  typedef enum logic [1:0] {
    PhFlag   = 2'd0,
    PhSymbol = 2'd1,
    PhReady  = 2'd2,
    PhFailed = 2'd3
  } phase_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0] event_res;
    logic [7:0] symbol;
    logic [2:0] error_code;
  } out_item_t;

  // A pending child slot: the parent node and the side (1 is right).
  typedef struct packed {
    logic [NodeW-1:0] node;
    logic             side;
  } slot_t;

  // One child link as kept in the parent's entry.
  typedef struct packed {
    logic                  leaf;
    logic [NodeW-1:0]      idx;
    logic [SymbolBits-1:0] sym;
  } link_t;

  typedef struct packed {
    logic             clear;
    logic             pop;
    logic             push;
    logic [NodeW-1:0] node;
  } stack_cmd_t;

  typedef struct packed {
    logic             we;
    logic             side;
    logic [NodeW-1:0] addr;
    link_t            data;
  } link_wr_t;

endpackage

>>> design/huffman_tree_load_and_decode.sv
// Huffman tree loader and decoder. The block takes one item per clock cycle
// on the input channel: a tree header bit, a leaf symbol byte, a payload bit
// or a restart is handled in the cycle of its transfer, and any result is
// written into the output register at the end of that cycle. The rate is set
// by the node memory read port: each node's child links, together with
// whether a child is a leaf and its symbol, are kept in the parent's entry,
// and the entry of the current walk node is always waiting in the read
// registers, so one payload bit costs one read.
// The input stalls only while the output register holds a result that the
// downstream side stalls. First send a preorder header (flag 0 for an
// internal node, flag 1 for a leaf followed by its symbol byte); a load
// complete event ends it, after which payload bits decode, 1 to the right and
// 0 to the left, with one symbol event per leaf reached. Errors report a
// payload bit before a tree, an item out of order, a node or stack overflow,
// and a tree that is a single leaf; after an overflow or a single-leaf tree
// the load must be restarted. A restart gives no result.
`include "huffman_tree_load_and_decode_macros.svh"

module huffman_tree_load_and_decode
  import htld_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  phase_e               phase_q, phase_d;
  logic [NodeCntW-1:0]  nodes_q, nodes_d;
  logic [NodeW-1:0]     walk_q, walk_d;
  slot_t                link_q, link_d;
  logic                 has_link_q, has_link_d;
  logic                 out_valid_q;
  out_item_t            out_q;

  logic                 in_acc;
  logic                 res_valid;
  out_item_t            res;
  stack_cmd_t           cmd;
  link_wr_t             wr;
  slot_t                top;
  logic [StackCntW-1:0] fill;
  link_t                sel;
  logic [NodeW-1:0]     node_new;
  logic                 node_full;
  logic                 can_pop;
  logic [StackCntW:0]   after_pop;
  logic                 too_deep;

  // A new item may enter whenever the output register is free or is being
  // emptied in this cycle.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign node_new  = nodes_q[NodeW-1:0];
  assign node_full = nodes_q >= NodeCntW'(MaxNodes);
  // Every node but the root is linked into the slot on top of the stack.
  assign can_pop   = (nodes_q != '0) && (fill != '0);
  assign after_pop = can_pop ? {1'b0, fill} - (StackCntW + 1)'(1) : {1'b0, fill};
  assign too_deep  = (after_pop + (StackCntW + 1)'(2)) > (StackCntW + 1)'(StackDepth);

  always_comb begin
    phase_d    = phase_q;
    nodes_d    = nodes_q;
    walk_d     = walk_q;
    link_d     = link_q;
    has_link_d = has_link_q;
    res_valid  = 1'b0;
    res        = '{event_res: EvError, symbol: '0, error_code: ErrNone};
    cmd        = '{clear: 1'b0, pop: 1'b0, push: 1'b0, node: node_new};
    wr         = '{we: 1'b0, side: link_q.side, addr: link_q.node,
                   data: '{leaf: 1'b1, idx: '0, sym: SymbolBits'(in_data_i.value)}};
    if (in_acc) begin
      unique case (kind_e'(in_data_i.kind))
        KindRestart: begin
          // The node memory keeps its contents; a new load overwrites
          // every link that the new tree reaches.
          phase_d   = PhFlag;
          nodes_d   = '0;
          walk_d    = '0;
          cmd.clear = 1'b1;
        end
        KindPayload: begin
          if (phase_q != PhReady) begin
            res_valid      = 1'b1;
            res.error_code = ErrNoTree;
          end else if (sel.leaf) begin
            walk_d        = '0;
            res_valid     = 1'b1;
            res.event_res = EvSymbol;
            res.symbol    = 8'(sel.sym);
          end else begin
            walk_d = sel.idx;
          end
        end
        KindFlag: begin
          if (phase_q != PhFlag) begin
            res_valid      = 1'b1;
            res.error_code = ErrOrder;
          end else if (node_full) begin
            phase_d        = PhFailed;
            res_valid      = 1'b1;
            res.error_code = ErrOverflow;
          end else if (in_data_i.value[0]) begin
            // Leaf: remember the parent slot, the link is written together
            // with the symbol byte that follows.
            cmd.pop    = can_pop;
            link_d     = top;
            has_link_d = can_pop;
            nodes_d    = nodes_q + NodeCntW'(1);
            phase_d    = PhSymbol;
          end else if (too_deep) begin
            phase_d        = PhFailed;
            res_valid      = 1'b1;
            res.error_code = ErrOverflow;
          end else begin
            cmd.pop  = can_pop;
            cmd.push = 1'b1;
            wr.we    = can_pop;
            wr.side  = top.side;
            wr.addr  = top.node;
            wr.data  = '{leaf: 1'b0, idx: node_new, sym: '0};
            nodes_d  = nodes_q + NodeCntW'(1);
          end
        end
        KindSymbol: begin
          if (phase_q != PhSymbol) begin
            res_valid      = 1'b1;
            res.error_code = ErrOrder;
          end else begin
            wr.we = has_link_q;
            if (fill != '0) begin
              phase_d = PhFlag;
            end else begin
              // The stack has emptied, so the header is complete.
              walk_d    = '0;
              res_valid = 1'b1;
              if (nodes_q <= NodeCntW'(1)) begin
                phase_d        = PhFailed;
                res.error_code = ErrSingleLeaf;
              end else begin
                phase_d       = PhReady;
                res.event_res = EvLoadDone;
              end
            end
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  htld_stack u_stack (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd),
    .top_o (top),
    .fill_o(fill)
  );

  // The node memory is read at the next walk node, so the links of the
  // node that the next payload bit starts from are ready in its read
  // registers. A write to that entry in the same cycle is passed through.
  htld_node_mem u_node_mem (
    .clk_i (clk_i),
    .wr_i  (wr),
    .walk_i(walk_d),
    .bit_i (in_data_i.value[0]),
    .link_o(sel)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhFlag;
      nodes_q     <= '0;
      walk_q      <= '0;
      has_link_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      nodes_q    <= nodes_d;
      walk_q     <= walk_d;
      has_link_q <= has_link_d;
      if (!out_valid_q || !out_stall_i) begin
        out_valid_q <= res_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    link_q <= link_d;
    if (!out_valid_q || !out_stall_i) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `HTLD_ASSERT(StackWithinDepth, fill <= StackCntW'(StackDepth), "stack fill exceeds depth")
  `HTLD_ASSERT(NodesWithinMax, nodes_q <= NodeCntW'(MaxNodes), "node count exceeds memory")
  `HTLD_ASSERT(ReadyWithEmptyStack, (phase_q != PhReady) || (fill == '0),
               "decode phase with pending slots")
  `HTLD_ASSERT_NEXT(SymbolReturnsToRoot,
                    in_acc && res_valid && (res.event_res == EvSymbol),
                    walk_q == '0, "walk did not return to the root after a leaf")

endmodule

>>> design/htld_ram.sv
module htld_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Write-first: a read of the address written in the same cycle returns the new word.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= (we_i && (waddr_i == raddr_i)) ? wdata_i : mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/htld_stack.sv
module htld_stack
  import htld_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  stack_cmd_t           cmd_i,
  output slot_t                top_o,
  output logic [StackCntW-1:0] fill_o
);

  // The top entry lives in a register or, after a pop, in the RAM read
  // register; entries below the top live in the RAM.
  logic [StackCntW-1:0]  sp_q, sp_d, after_pop;
  slot_t                 top_q, top_d;
  logic                  from_ram_q, from_ram_d;
  logic                  we, re;
  logic [StackAddrW-1:0] waddr, raddr;
  slot_t                 wdata, rdata;

  always_comb begin
    after_pop  = cmd_i.pop ? sp_q - StackCntW'(1) : sp_q;
    sp_d       = sp_q;
    top_d      = top_q;
    from_ram_d = from_ram_q;
    we         = 1'b0;
    re         = 1'b0;
    waddr      = StackAddrW'(after_pop);
    raddr      = StackAddrW'(sp_q - StackCntW'(2));
    wdata      = '{node: cmd_i.node, side: 1'b1};
    priority if (cmd_i.clear) begin
      sp_d       = '0;
      from_ram_d = 1'b0;
    end else if (cmd_i.push) begin
      // The right slot goes below, the left slot becomes the new top.
      we         = 1'b1;
      top_d      = '{node: cmd_i.node, side: 1'b0};
      from_ram_d = 1'b0;
      sp_d       = after_pop + StackCntW'(2);
    end else if (cmd_i.pop) begin
      re         = 1'b1;
      from_ram_d = 1'b1;
      sp_d       = after_pop;
    end else begin
      sp_d = sp_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q       <= '0;
      from_ram_q <= 1'b0;
    end else begin
      sp_q       <= sp_d;
      from_ram_q <= from_ram_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
  end

  htld_ram #(
    .Width($bits(slot_t)),
    .Depth(StackDepth)
  ) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign top_o  = from_ram_q ? rdata : top_q;
  assign fill_o = sp_q;

endmodule

>>> design/htld_node_mem.sv
module htld_node_mem
  import htld_pkg::*;
(
  input  logic             clk_i,
  input  link_wr_t         wr_i,
  input  logic [NodeW-1:0] walk_i,
  input  logic             bit_i,
  output link_t            link_o
);

  // Each node keeps its left and right child links in two RAMs. Both are
  // read at the next walk node every cycle, so the links of the current
  // node are always waiting in the read registers.
  link_t left_rd, right_rd;
  logic  left_we, right_we;

  assign left_we  = wr_i.we && !wr_i.side;
  assign right_we = wr_i.we && wr_i.side;

  htld_ram #(
    .Width($bits(link_t)),
    .Depth(MaxNodes)
  ) u_left_ram (
    .clk_i  (clk_i),
    .we_i   (left_we),
    .waddr_i(wr_i.addr),
    .wdata_i(wr_i.data),
    .re_i   (1'b1),
    .raddr_i(walk_i),
    .rdata_o(left_rd)
  );

  htld_ram #(
    .Width($bits(link_t)),
    .Depth(MaxNodes)
  ) u_right_ram (
    .clk_i  (clk_i),
    .we_i   (right_we),
    .waddr_i(wr_i.addr),
    .wdata_i(wr_i.data),
    .re_i   (1'b1),
    .raddr_i(walk_i),
    .rdata_o(right_rd)
  );

  assign link_o = bit_i ? right_rd : left_rd;

endmodule
